// ===== rtl/core/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    // Bits shifted per byte
    localparam int BITS_PER_BYTE = 8;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Reset value of the phase length register
    localparam logic [9:0] TICKS_PER_PHASE_RST = 10'd5;

    // Input kind codes as they arrive on the port
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_STOP  = 3'd4;

    // Command that the back end is executing
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_STOP  = 3'd4
    } t_cmd;

    // Class of a word after the front end has looked at it
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_CMD  = 2'd1,
        OP_NONE = 2'd2
    } t_op;

    // Classified word held in the queue
    typedef struct packed {
        t_op        op;
        t_cmd       cmd;
        logic [7:0] byte_out;
        logic       ack_level;
        logic       sda_in;
    } t_word;

endpackage

// ===== rtl/core/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: front queue and phase engine.
`timescale 1ns / 1ps

// Open-drain I2C master driven one word at a time: each input word is a
// timing tick or a start, write byte, read byte or stop command, and each
// word yields exactly one result word carrying the SCL/SDA drive levels,
// busy and done flags, the last ACK seen and the last byte read. Commands
// are taken only while idle; one bus phase lasts ticks_per_phase ticks.
// Up to one word per clock is accepted and processed while neither channel stalls;
// each accepted word passes through the queue and then the phase engine, whose
// outcome is held in the result register.
// A short queue in front of the engine and the result register behind it let
// input and output stall independently.
module i2c_master_byte_engine #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_byte_out,
    input  logic        i_ack_level,
    input  logic        i_sda_in,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_scl_low,
    output logic        o_sda_low,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_ack_seen,
    output logic [7:0]  o_byte_in
);
    import i2cm_pkg::*;

    logic   w_q_valid;
    logic   w_q_pop;
    t_word  w_q_word;

    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_byte_out  (i_byte_out),
        .i_ack_level (i_ack_level),
        .i_sda_in    (i_sda_in),
        .o_q_valid   (w_q_valid),
        .o_q_word    (w_q_word),
        .i_q_pop     (w_q_pop)
    );

    i2cm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_word    (w_q_word),
        .o_q_pop     (w_q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_scl_low   (o_scl_low),
        .o_sda_low   (o_sda_low),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_ack_seen  (o_ack_seen),
        .o_byte_in   (o_byte_in)
    );

endmodule

// ===== rtl/core/i2cm_front.sv =====
// Front end: accepts input words, classifies them and queues them for the engine.
`timescale 1ns / 1ps

module i2cm_front #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_kind,
    input  logic [7:0]        i_byte_out,
    input  logic              i_ack_level,
    input  logic              i_sda_in,
    // queue read side
    output logic              o_q_valid,
    output i2cm_pkg::t_word   o_q_word,
    input  logic              i_q_pop
);
    import i2cm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_word              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    t_word              w_word;
    logic               w_push;

    // classify the incoming word
    always_comb begin
        w_word.byte_out  = i_byte_out;
        w_word.ack_level = i_ack_level;
        w_word.sda_in    = i_sda_in;
        case (i_kind)
            KIND_TICK: begin
                w_word.op  = OP_TICK;
                w_word.cmd = CMD_IDLE;
            end
            KIND_START: begin
                w_word.op  = OP_CMD;
                w_word.cmd = CMD_START;
            end
            KIND_WRITE: begin
                w_word.op  = OP_CMD;
                w_word.cmd = CMD_WRITE;
            end
            KIND_READ: begin
                w_word.op  = OP_CMD;
                w_word.cmd = CMD_READ;
            end
            KIND_STOP: begin
                w_word.op  = OP_CMD;
                w_word.cmd = CMD_STOP;
            end
            default: begin
                // unknown kinds still produce a result, with no state change
                w_word.op  = OP_NONE;
                w_word.cmd = CMD_IDLE;
            end
        endcase
    end

    assign o_stall   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign o_q_word  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, i_q_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_word;
        end
    end

endmodule

// ===== rtl/core/i2cm_back.sv =====
// Back end: bus phase sequencer, byte shifter and result register.
`timescale 1ns / 1ps

module i2cm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [9:0]        i_cfg_wdata,
    // queue side
    input  logic              i_q_valid,
    input  i2cm_pkg::t_word   i_q_word,
    output logic              o_q_pop,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_scl_low,
    output logic              o_sda_low,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic              o_ack_seen,
    output logic [7:0]        o_byte_in
);
    import i2cm_pkg::*;

    // engine state
    t_cmd        r_cmd,       n_cmd;
    logic [9:0]  r_timer,     n_timer;
    logic [2:0]  r_step,      n_step;
    logic [3:0]  r_bit_cnt,   n_bit_cnt;
    logic [7:0]  r_shift,     n_shift;
    logic        r_ack_choice, n_ack_choice;
    logic        r_ack_latch, n_ack_latch;
    logic [1:0]  r_lines,     n_lines;    // bit0 SCL low, bit1 SDA low
    logic [7:0]  r_read_hold, n_read_hold;
    logic        n_done;
    logic [9:0]  r_tpp;

    // result register
    logic        r_out_valid;
    logic        r_scl_low, r_sda_low, r_busy, r_done, r_ack_seen;
    logic [7:0]  r_byte_in;

    logic [9:0]  w_timer_inc;
    logic [9:0]  w_limit;
    logic [3:0]  w_bit_cnt_inc;

    // line levels on entry to a phase
    function automatic logic [1:0] phase_lines(
        input t_cmd       cmd,
        input logic [2:0] step,
        input logic [3:0] bit_cnt,
        input logic [7:0] shift,
        input logic       ack_choice,
        input logic [1:0] lines_now
    );
        logic scl;
        logic sda;
        scl = 1'b0;
        sda = 1'b0;
        case (cmd)
            CMD_START: begin
                sda = (step == 3'd1);
            end
            CMD_WRITE: begin
                scl = !step[0];
                if (step < 3'd2) begin
                    sda = !shift[3'd7 - bit_cnt[2:0]];
                end
            end
            CMD_READ: begin
                scl = !step[0];
                if (step >= 3'd2) begin
                    sda = !ack_choice;
                end
            end
            CMD_STOP: begin
                scl = (step == 3'd0);
                sda = (step < 3'd2);
            end
            default: begin
                return lines_now;
            end
        endcase
        return {sda, scl};
    endfunction

    assign o_q_pop       = i_q_valid && (!r_out_valid || !i_stall);
    assign w_timer_inc   = r_timer + 10'd1;
    assign w_limit       = (r_tpp == '0) ? 10'd1 : r_tpp;
    assign w_bit_cnt_inc = r_bit_cnt + 4'd1;

    // next state of the engine for the word being popped
    always_comb begin
        n_cmd        = r_cmd;
        n_timer      = r_timer;
        n_step       = r_step;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_ack_latch  = r_ack_latch;
        n_lines      = r_lines;
        n_read_hold  = r_read_hold;
        n_done       = 1'b0;

        if (r_cmd == CMD_IDLE) begin
            // idle: a command starts a sequence, ticks do nothing
            if (i_q_word.op == OP_CMD) begin
                n_cmd     = i_q_word.cmd;
                n_timer   = '0;
                n_step    = '0;
                n_bit_cnt = '0;
                if (i_q_word.cmd == CMD_WRITE) begin
                    n_shift = i_q_word.byte_out;
                end else if (i_q_word.cmd == CMD_READ) begin
                    n_shift      = '0;
                    n_ack_choice = i_q_word.ack_level;
                end
                n_lines = phase_lines(n_cmd, n_step, n_bit_cnt, n_shift,
                                      n_ack_choice, r_lines);
            end
        end else if (i_q_word.op == OP_TICK) begin
            // busy: commands are ignored, ticks run the phase timer
            n_timer = w_timer_inc;
            if (w_timer_inc >= w_limit) begin
                n_timer = '0;
                case (r_cmd)
                    CMD_START: begin
                        if (r_step == 3'd0) begin
                            n_step = 3'd1;
                        end else begin
                            n_done = 1'b1;
                        end
                    end
                    CMD_WRITE, CMD_READ: begin
                        if (r_step == 3'd0 || r_step == 3'd2) begin
                            n_step = r_step + 3'd1;
                        end else if (r_step == 3'd1) begin
                            // end of a data bit
                            if (r_cmd == CMD_READ) begin
                                n_shift = {r_shift[6:0], i_q_word.sda_in};
                            end
                            n_bit_cnt = w_bit_cnt_inc;
                            n_step    = (w_bit_cnt_inc < 4'(BITS_PER_BYTE)) ? 3'd0 : 3'd2;
                        end else begin
                            // end of the ACK slot
                            if (r_cmd == CMD_WRITE) begin
                                n_ack_latch = i_q_word.sda_in;
                            end else begin
                                n_read_hold = r_shift;
                            end
                            n_done = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        if (r_step < 3'd2) begin
                            n_step = r_step + 3'd1;
                        end else begin
                            n_done = 1'b1;
                        end
                    end
                    default: begin
                        n_done = 1'b1;
                    end
                endcase

                if (n_done) begin
                    // lines keep their last levels
                    n_cmd     = CMD_IDLE;
                    n_step    = '0;
                    n_bit_cnt = '0;
                end else begin
                    n_lines = phase_lines(n_cmd, n_step, n_bit_cnt, n_shift,
                                          n_ack_choice, r_lines);
                end
            end
        end
    end

    // engine state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= CMD_IDLE;
            r_timer      <= '0;
            r_step       <= '0;
            r_bit_cnt    <= '0;
            r_shift      <= '0;
            r_ack_choice <= 1'b0;
            r_ack_latch  <= 1'b1;
            r_lines      <= '0;
            r_read_hold  <= '0;
        end else if (o_q_pop) begin
            r_cmd        <= n_cmd;
            r_timer      <= n_timer;
            r_step       <= n_step;
            r_bit_cnt    <= n_bit_cnt;
            r_shift      <= n_shift;
            r_ack_choice <= n_ack_choice;
            r_ack_latch  <= n_ack_latch;
            r_lines      <= n_lines;
            r_read_hold  <= n_read_hold;
        end
    end

    // phase length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpp <= TICKS_PER_PHASE_RST;
        end else if (i_cfg_we) begin
            r_tpp <= i_cfg_wdata;
        end
    end

    // result register, one word per popped input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_scl_low  <= n_lines[0];
            r_sda_low  <= n_lines[1];
            r_busy     <= (n_cmd != CMD_IDLE);
            r_done     <= n_done;
            r_ack_seen <= n_ack_latch;
            r_byte_in  <= n_read_hold;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_scl_low  = r_scl_low;
    assign o_sda_low  = r_sda_low;
    assign o_busy_res = r_busy;
    assign o_done_res = r_done;
    assign o_ack_seen = r_ack_seen;
    assign o_byte_in  = r_byte_in;

endmodule

// ===== sim/i2c_master_byte_engine_tb.sv =====
// Self-checking testbench for the I2C master byte engine: directed phases, then random bus traffic.
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;
    import i2cm_pkg::*;

    // Kind codes the block must ignore
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // How tick runs drive the sampled SDA level
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 200;
    localparam int RANDOM_WORDS = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int SLOW_TICKS   = 64;

    // Line levels and flags carried by one result word
    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy;
        logic       done;
        logic       ack_seen;
        logic [7:0] byte_in;
    } t_line_state;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [9:0] i_cfg_wdata = '0;
    logic       i_valid     = 1'b0;
    logic       o_stall;
    logic [2:0] i_kind      = KIND_TICK;
    logic [7:0] i_byte_out  = '0;
    logic       i_ack_level = 1'b0;
    logic       i_sda_in    = 1'b0;
    logic       o_valid;
    logic       i_stall     = 1'b0;
    logic       o_scl_low;
    logic       o_sda_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_ack_seen;
    logic [7:0] o_byte_in;

    t_line_state expected_lines[$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    bit          gaps_on      = 1'b1;

    // Engine model state
    logic [9:0] phase_len;
    logic [9:0] tick_count;
    logic [2:0] phase_idx;
    logic [3:0] bit_idx;
    logic [7:0] shift_byte;
    logic [7:0] last_read;
    t_cmd       active_cmd;
    logic       nack_choice;
    logic       ack_flag;
    logic       drive_scl;
    logic       drive_sda;

    i2c_master_byte_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_byte_out  (i_byte_out),
        .i_ack_level (i_ack_level),
        .i_sda_in    (i_sda_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_scl_low   (o_scl_low),
        .o_sda_low   (o_sda_low),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_ack_seen  (o_ack_seen),
        .o_byte_in   (o_byte_in)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        if (!gaps_on) return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic void model_reset();
        phase_len   = TICKS_PER_PHASE_RST;
        tick_count  = '0;
        phase_idx   = '0;
        bit_idx     = '0;
        shift_byte  = '0;
        last_read   = '0;
        active_cmd  = CMD_IDLE;
        nack_choice = 1'b0;
        ack_flag    = 1'b1;   // no ACK seen yet
        drive_scl   = 1'b0;
        drive_sda   = 1'b0;
    endfunction

    // Line levels on entry to the current phase
    function automatic void set_line_drive();
        case (active_cmd)
            CMD_START: begin
                drive_scl = 1'b0;
                drive_sda = (phase_idx == 3'd1);
            end
            CMD_WRITE: begin
                drive_scl = ~phase_idx[0];
                // data bits pull SDA low for a zero; ACK slot releases it
                drive_sda = (phase_idx < 3'd2) ? ~shift_byte[3'd7 - bit_idx[2:0]] : 1'b0;
            end
            CMD_READ: begin
                drive_scl = ~phase_idx[0];
                drive_sda = (phase_idx >= 3'd2) ? ~nack_choice : 1'b0;
            end
            CMD_STOP: begin
                drive_scl = (phase_idx == 3'd0);
                drive_sda = (phase_idx < 3'd2);
            end
            default: ;
        endcase
    endfunction

    // Close the current phase; returns 1 when the command is complete
    function automatic bit finish_phase(input logic sda);
        bit last;
        last = 1'b0;
        case (active_cmd)
            CMD_START: begin
                if (phase_idx == 3'd0) phase_idx = 3'd1;
                else last = 1'b1;
            end
            CMD_WRITE, CMD_READ: begin
                if (phase_idx == 3'd0 || phase_idx == 3'd2) begin
                    phase_idx = phase_idx + 3'd1;
                end else if (phase_idx == 3'd1) begin
                    if (active_cmd == CMD_READ) shift_byte = {shift_byte[6:0], sda};
                    bit_idx   = bit_idx + 4'd1;
                    phase_idx = (bit_idx < BITS_PER_BYTE) ? 3'd0 : 3'd2;
                end else begin
                    if (active_cmd == CMD_WRITE) ack_flag = sda;
                    else last_read = shift_byte;
                    last = 1'b1;
                end
            end
            CMD_STOP: begin
                if (phase_idx < 3'd2) phase_idx = phase_idx + 3'd1;
                else last = 1'b1;
            end
            default: last = 1'b1;
        endcase
        return last;
    endfunction

    // Apply one word to the engine model and return the line state it leaves
    function automatic t_line_state engine_next(input logic [2:0] kind, input logic [7:0] byte_out,
                                                input logic ack_level, input logic sda_in);
        t_line_state res;
        logic [9:0]  limit;
        res.done = 1'b0;
        if (active_cmd == CMD_IDLE) begin
            if (kind >= KIND_START && kind <= KIND_STOP) begin
                active_cmd = t_cmd'(kind);
                tick_count = '0;
                phase_idx  = '0;
                bit_idx    = '0;
                if (kind == KIND_WRITE) begin
                    shift_byte = byte_out;
                end else if (kind == KIND_READ) begin
                    shift_byte  = '0;
                    nack_choice = ack_level;
                end
                set_line_drive();
            end
        end else if (kind == KIND_TICK) begin
            // a zero phase length behaves as one
            limit      = (phase_len == '0) ? 10'd1 : phase_len;
            tick_count = tick_count + 10'd1;
            if (tick_count >= limit) begin
                tick_count = '0;
                if (finish_phase(sda_in)) begin
                    active_cmd = CMD_IDLE;
                    phase_idx  = '0;
                    bit_idx    = '0;
                    res.done   = 1'b1;
                end else begin
                    set_line_drive();
                end
            end
        end
        res.scl_low  = drive_scl;
        res.sda_low  = drive_sda;
        res.busy     = (active_cmd != CMD_IDLE);
        res.ack_seen = ack_flag;
        res.byte_in  = last_read;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Present one word and wait until it is taken
    task automatic send_word(input logic [2:0] kind, input logic [7:0] byte_out,
                             input logic ack_level, input logic sda_in);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_byte_out  <= byte_out;
        i_ack_level <= ack_level;
        i_sda_in    <= sda_in;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_lines.push_back(engine_next(kind, byte_out, ack_level, sda_in));
    endtask

    // Tick the engine until the running command completes
    task automatic run_until_idle(input int sda_mode);
        logic sda;
        while (active_cmd != CMD_IDLE) begin
            if (sda_mode == SDA_LOW) sda = 1'b0;
            else if (sda_mode == SDA_HIGH) sda = 1'b1;
            else sda = 1'($urandom_range(0, 1));
            send_word(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
        end
    endtask

    // Phase length write, only once every result has drained
    task automatic set_phase_ticks(input logic [9:0] value);
        i_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        phase_len = value;
    endtask

    // Idle engine: ticks and unused kinds change nothing
    task automatic test_idle_words();
        send_word(KIND_TICK, 8'h00, 1'b0, 1'b0);
        send_word(KIND_TICK, 8'hFF, 1'b1, 1'b1);
        for (int k = int'(KIND_SPARE_LO); k <= int'(KIND_SPARE_HI); k++)
            send_word(k[2:0], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    // Start condition at the reset phase length
    task automatic test_start_default();
        send_word(KIND_START, 8'h00, 1'b0, 1'b0);
        run_until_idle(SDA_RANDOM);
    endtask

    task automatic test_write_extremes();
        set_phase_ticks(10'd1);
        send_word(KIND_WRITE, 8'h00, 1'b0, 1'b0);
        run_until_idle(SDA_LOW);
        send_word(KIND_WRITE, 8'hFF, 1'b1, 1'b1);
        run_until_idle(SDA_HIGH);
        send_word(KIND_WRITE, 8'hA5, 1'b0, 1'b0);
        run_until_idle(SDA_RANDOM);
    endtask

    task automatic test_read_extremes();
        send_word(KIND_READ, 8'h00, 1'b0, 1'b0);
        run_until_idle(SDA_HIGH);
        send_word(KIND_READ, 8'hFF, 1'b1, 1'b1);
        run_until_idle(SDA_LOW);
        send_word(KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        run_until_idle(SDA_RANDOM);
    endtask

    // Commands and unused kinds arriving mid-command are dropped
    task automatic test_busy_commands();
        set_phase_ticks(10'd2);
        send_word(KIND_WRITE, 8'h3C, 1'b0, 1'b0);
        send_word(KIND_TICK, 8'h00, 1'b0, 1'b1);
        for (int k = int'(KIND_START); k <= int'(KIND_SPARE_HI); k++)
            send_word(k[2:0], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        run_until_idle(SDA_RANDOM);
        send_word(KIND_STOP, 8'h00, 1'b0, 1'b0);
        send_word(KIND_TICK, 8'h00, 1'b0, 1'b0);
        send_word(KIND_START, 8'h00, 1'b0, 1'b0);
        send_word(KIND_READ, 8'hFF, 1'b1, 1'b1);
        run_until_idle(SDA_RANDOM);
    endtask

    // Zero phase length runs like one tick per phase
    task automatic test_zero_phase_ticks();
        set_phase_ticks(10'd0);
        send_word(KIND_START, 8'h00, 1'b0, 1'b0);
        run_until_idle(SDA_RANDOM);
        send_word(KIND_STOP, 8'h00, 1'b0, 1'b0);
        run_until_idle(SDA_RANDOM);
    endtask

    // Longest phase length: the timer climbs without ending a phase, then a
    // short length ends it on the next tick
    task automatic test_slowest_phase();
        gaps_on = 1'b0;
        set_phase_ticks(10'd1023);
        send_word(KIND_START, 8'h00, 1'b0, 1'b0);
        repeat (SLOW_TICKS)
            send_word(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        set_phase_ticks(10'd1);
        run_until_idle(SDA_RANDOM);
        send_word(KIND_STOP, 8'h00, 1'b0, 1'b0);
        run_until_idle(SDA_RANDOM);
        gaps_on = 1'b1;
    endtask

    // Random frames: start, address, data bytes, stop, with noise mixed in
    task automatic test_random_traffic();
        int         taken;
        int         pick;
        int         frame_bytes;
        bit         in_frame;
        bit         addr_next;
        logic [2:0] kind;
        logic [9:0] ticks;
        taken     = 0;
        in_frame  = 1'b0;
        addr_next = 1'b0;
        frame_bytes = 0;
        while (taken < RANDOM_WORDS) begin
            if ($urandom_range(0, 199) == 0) gaps_on = ~gaps_on;
            if (active_cmd == CMD_IDLE) begin
                if ($urandom_range(0, 9) == 0) begin
                    // any kind at all; only real commands take effect
                    kind = 3'($urandom_range(0, 7));
                    if (kind >= KIND_START && kind <= KIND_STOP) taken++;
                    send_word(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end else begin
                    if (!in_frame) begin
                        if ($urandom_range(0, 4) == 0) begin
                            pick = $urandom_range(0, 9);
                            if (pick < 6) ticks = 10'd1;
                            else if (pick < 8) ticks = 10'($urandom_range(2, 3));
                            else if (pick == 8) ticks = 10'd0;
                            else ticks = 10'($urandom_range(4, 9));
                            set_phase_ticks(ticks);
                        end
                        kind        = KIND_START;
                        in_frame    = 1'b1;
                        addr_next   = 1'b1;
                        frame_bytes = $urandom_range(1, 4);
                    end else if (addr_next) begin
                        kind      = KIND_WRITE;
                        addr_next = 1'b0;
                    end else if (frame_bytes == 0) begin
                        kind     = KIND_STOP;
                        in_frame = 1'b0;
                    end else begin
                        kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
                        frame_bytes--;
                    end
                    taken++;
                    send_word(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            end else if ($urandom_range(0, 11) == 0) begin
                // dropped while busy
                send_word(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                taken++;
                send_word(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Result side: random stalls, compare each word with the oldest prediction
    initial begin : result_checker
        t_line_state want;
        int          hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = draw_wait();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (expected_lines.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected", $time);
            end else begin
                want = expected_lines.pop_front();
                check_field("scl_low", 8'(want.scl_low), 8'(o_scl_low));
                check_field("sda_low", 8'(want.sda_low), 8'(o_sda_low));
                check_field("busy_res", 8'(want.busy), 8'(o_busy_res));
                check_field("done_res", 8'(want.done), 8'(o_done_res));
                check_field("ack_seen", 8'(want.ack_seen), 8'(o_ack_seen));
                check_field("byte_in", want.byte_in, o_byte_in);
            end
        end
    end

    // Watchdog on cycles where neither channel moves a word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("i2c_master_byte_engine test failed");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        model_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_words();
        test_start_default();
        test_write_extremes();
        test_read_extremes();
        test_busy_commands();
        test_zero_phase_ticks();
        test_slowest_phase();
        test_random_traffic();
        i_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_lines.size() == 0)
            $display("i2c_master_byte_engine test passed");
        else
            $display("i2c_master_byte_engine test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_back.sv
rtl/core/i2c_master_byte_engine.sv
sim/i2c_master_byte_engine_tb.sv
